// ----- design/tcea_pkg.sv -----
`timescale 1ns / 1ps

package tcea_pkg;

  // Event codes carried by the action field.
  typedef enum logic [1:0] {
    ACT_ARRIVE = 2'd0,
    ACT_RETRY  = 2'd1,
    ACT_DEPART = 2'd2,
    ACT_IDLE   = 2'd3
  } act_t;

  // Occupant and streak class tags.
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_A    = 2'd1,
    KIND_B    = 2'd2
  } kind_t;

  // Configuration register indexes.
  localparam logic REG_SLOT_CAPACITY = 1'b0;
  localparam logic REG_STREAK_MAX    = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [7:0] SLOT_CAPACITY_RST = 8'd3;
  localparam logic [7:0] STREAK_MAX_RST    = 8'd5;

  // Saturation point of the streak length.
  localparam logic [7:0] STREAK_LEN_MAX = 8'd255;

  // One accepted event as held in the input register.
  typedef struct packed {
    act_t action;
    logic user_class;
  } item_t;

  // Occupancy and streak state.
  typedef struct packed {
    logic [7:0] occ;
    kind_t      holder;
    kind_t      streak;
    logic [7:0] len;
  } core_t;

  // Per-event result flags.
  typedef struct packed {
    logic granted;
    logic fault;
  } flags_t;

  // The opposite class; no streak maps to no class.
  function automatic kind_t other_kind(kind_t k);
    kind_t r;
    case (k)
      KIND_A:  r = KIND_B;
      KIND_B:  r = KIND_A;
      default: r = KIND_NONE;
    endcase
    return r;
  endfunction

endpackage

// ----- design/two_class_exclusive_admission_arbiter.sv -----
`timescale 1ns / 1ps
// Channel  | Handshake           | Payload
// ---------+---------------------+--------------------------------------------
// input    | in_valid, in_ready  | action, user_class
// result   | out_valid, out_ready| granted, fault, occupancy, inside_kind,
//          |                     | streak_kind, streak_count
// config   | cfg_valid, cfg_ready| cfg_index, cfg_data
//
// One item per cycle is sustained while results are taken; an item passes
// from acceptance through the input register and then the result register.
// The occupancy and streak state is updated in the same cycle the result is
// loaded, so consecutive items see each other's effects with no bubbles.
// Synchronous reset clears state and configures capacity 3, streak limit 5.
// A stalled result holds the pipe; cfg_ready is always high.

module two_class_exclusive_admission_arbiter #(
  parameter int MAX_WAITERS = 65535
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  logic       user_class,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       granted,
  output logic       fault,
  output logic [7:0] occupancy,
  output logic [1:0] inside_kind,
  output logic [1:0] streak_kind,
  output logic [7:0] streak_count,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import tcea_pkg::*;

  localparam int WAIT_W = $clog2(MAX_WAITERS + 1);

  logic              item_valid;
  item_t             item;
  logic              take;
  core_t             cur;
  core_t             nxt;
  logic [WAIT_W-1:0] wait_a;
  logic [WAIT_W-1:0] wait_b;
  logic [WAIT_W-1:0] wait_a_next;
  logic [WAIT_W-1:0] wait_b_next;
  flags_t            flags;
  logic [7:0]        slot_capacity;
  logic [7:0]        streak_max;

  // The held item moves on whenever the result register is free.
  assign take = item_valid && (!out_valid || out_ready);

  tcea_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .user_class (user_class),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  tcea_admit #(
    .MAX_WAITERS (MAX_WAITERS),
    .WAIT_W      (WAIT_W)
  ) u_admit (
    .item          (item),
    .cur           (cur),
    .wait_a        (wait_a),
    .wait_b        (wait_b),
    .slot_capacity (slot_capacity),
    .streak_max    (streak_max),
    .nxt           (nxt),
    .wait_a_next   (wait_a_next),
    .wait_b_next   (wait_b_next),
    .flags         (flags)
  );

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_capacity <= SLOT_CAPACITY_RST;
      streak_max    <= STREAK_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SLOT_CAPACITY: slot_capacity <= cfg_data;
        REG_STREAK_MAX:    streak_max    <= cfg_data;
        default:           slot_capacity <= slot_capacity;
      endcase
    end
  end

  // Arbiter state advances as each item is resolved.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur.occ    <= 8'd0;
      cur.holder <= KIND_NONE;
      cur.streak <= KIND_NONE;
      cur.len    <= 8'd0;
      wait_a     <= '0;
      wait_b     <= '0;
    end else if (take) begin
      cur    <= nxt;
      wait_a <= wait_a_next;
      wait_b <= wait_b_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (take) begin
      granted      <= flags.granted;
      fault        <= flags.fault;
      occupancy    <= nxt.occ;
      inside_kind  <= nxt.holder;
      streak_kind  <= nxt.streak;
      streak_count <= nxt.len;
    end
  end

`ifndef SYNTHESIS
  // An empty resource reports no class inside, and the reverse.
  a_empty_tag : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((occupancy == 8'd0) == (inside_kind == KIND_NONE)))
    else $error("occupancy and inside class disagree");

  // A streak class exists exactly when the streak length is nonzero.
  a_streak_tag : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((streak_count == 8'd0) == (streak_kind == KIND_NONE)))
    else $error("streak class and streak length disagree");

  // An admitted class is both inside and the current streak holder.
  a_grant_class : assert property (@(posedge clk) disable iff (rst)
    (out_valid && granted) |-> ((streak_kind == inside_kind) && (inside_kind != KIND_NONE)))
    else $error("admission left inconsistent class state");

  // A fault and an admission never come from the same item.
  a_fault_grant : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(granted && fault))
    else $error("fault and grant reported together");

  // Occupancy grows only through an admission, by one.
  a_occ_step : assert property (@(posedge clk) disable iff (rst)
    (take && (nxt.occ != cur.occ) && flags.granted) |-> (nxt.occ == cur.occ + 8'd1))
    else $error("admission changed occupancy by more than one");
`endif

endmodule

// ----- design/tcea_in_stage.sv -----
`timescale 1ns / 1ps

module tcea_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      action,
  input  logic            user_class,
  input  logic            take,
  output logic            item_valid,
  output tcea_pkg::item_t item
);
  import tcea_pkg::*;

  // The register frees up in the same cycle that its item moves on.
  assign in_ready = !item_valid || take;

  // Valid flag of the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  // Payload of the input register.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.action     <= act_t'(action);
      item.user_class <= user_class;
    end
  end

endmodule

// ----- design/tcea_admit.sv -----
`timescale 1ns / 1ps

module tcea_admit #(
  parameter int MAX_WAITERS = 65535,
  parameter int WAIT_W      = 16
) (
  input  tcea_pkg::item_t  item,
  input  tcea_pkg::core_t  cur,
  input  logic [WAIT_W-1:0] wait_a,
  input  logic [WAIT_W-1:0] wait_b,
  input  logic [7:0]        slot_capacity,
  input  logic [7:0]        streak_max,
  output tcea_pkg::core_t  nxt,
  output logic [WAIT_W-1:0] wait_a_next,
  output logic [WAIT_W-1:0] wait_b_next,
  output tcea_pkg::flags_t flags
);
  import tcea_pkg::*;

  localparam logic [WAIT_W-1:0] WAIT_CAP = WAIT_W'(MAX_WAITERS);

  kind_t             tag;
  kind_t             due;
  logic [WAIT_W-1:0] wa;
  logic [WAIT_W-1:0] wb;
  logic [WAIT_W-1:0] due_wait;
  logic              ok;
  logic              clear;

  // Decision and next state for one event.
  always_comb begin
    tag   = item.user_class ? KIND_B : KIND_A;
    wa    = wait_a;
    wb    = wait_b;
    nxt   = cur;
    flags = '0;
    ok    = 1'b0;
    clear = 1'b0;

    // An arrive registers its waiter before admission is tried.
    if (item.action == ACT_ARRIVE) begin
      if (tag == KIND_A) begin
        if (wa < WAIT_CAP) wa = wa + 1'b1;
      end else begin
        if (wb < WAIT_CAP) wb = wb + 1'b1;
      end
    end

    // Class that the streak currently favors, and its waiters.
    due = (cur.len < streak_max) ? cur.streak : other_kind(cur.streak);
    if (due == KIND_A) begin
      due_wait = wa;
    end else if (due == KIND_B) begin
      due_wait = wb;
    end else begin
      due_wait = '0;
    end

    case (item.action) inside
      ACT_ARRIVE, ACT_RETRY: begin
        if (cur.occ >= slot_capacity) begin
          ok = 1'b0;
        end else if (cur.occ == 8'd0) begin
          if (cur.streak == KIND_NONE) begin
            ok = 1'b1;
          end else if (tag == due) begin
            ok = 1'b1;
          end else if (due_wait == '0) begin
            // Nobody of the favored class waits: drop the streak and admit.
            ok    = 1'b1;
            clear = 1'b1;
          end
        end else begin
          ok = (cur.holder == tag) && (tag == due);
        end

        if (ok) begin
          flags.granted = 1'b1;
          nxt.occ       = cur.occ + 8'd1;
          if (cur.occ == 8'd0) nxt.holder = tag;
          if (tag == KIND_A) begin
            if (wa != '0) wa = wa - 1'b1;
          end else begin
            if (wb != '0) wb = wb - 1'b1;
          end
          if (!clear && cur.streak == tag) begin
            if (cur.len != STREAK_LEN_MAX) nxt.len = cur.len + 8'd1;
          end else begin
            nxt.streak = tag;
            nxt.len    = 8'd1;
          end
        end
      end
      ACT_DEPART: begin
        if (cur.occ == 8'd0) begin
          flags.fault = 1'b1;
        end else begin
          nxt.occ = cur.occ - 8'd1;
          if (cur.occ == 8'd1) nxt.holder = KIND_NONE;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase

    wait_a_next = wa;
    wait_b_next = wb;
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import tcea_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [15:0] WAIT_LIMIT = 16'hFFFF;

  // One result item as seen on the result channel.
  typedef struct packed {
    logic       granted;
    logic       fault;
    logic [7:0] occupancy;
    kind_t      holder;
    kind_t      streak;
    logic [7:0] count;
  } outcome_t;

  // Tracks the arbiter's occupancy, streak and waiters, and holds the
  // outcomes still owed by the block in order of acceptance.
  class admission_tracker;
    logic [7:0]  capacity;
    logic [7:0]  run_cap;
    logic [7:0]  occupied;
    kind_t       holder;
    kind_t       run_kind;
    logic [7:0]  run_len;
    logic [15:0] wait_a;
    logic [15:0] wait_b;
    outcome_t    expected_outcomes[$];
    int          errors;

    function new();
      capacity = SLOT_CAPACITY_RST;
      run_cap = STREAK_MAX_RST;
      occupied = '0;
      holder = KIND_NONE;
      run_kind = KIND_NONE;
      run_len = '0;
      wait_a = '0;
      wait_b = '0;
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic [7:0] value);
      if (idx == REG_SLOT_CAPACITY) begin
        capacity = value;
      end else begin
        run_cap = value;
      end
    endfunction

    function kind_t opposite(kind_t k);
      if (k == KIND_A) return KIND_B;
      if (k == KIND_B) return KIND_A;
      return KIND_NONE;
    endfunction

    // Tries to let one requester of class k in and updates the state.
    function bit admit(kind_t k);
      kind_t       due;
      logic [15:0] due_waiters;
      bit          ok;
      ok = 1'b0;
      due = (run_len < run_cap) ? run_kind : opposite(run_kind);
      due_waiters = (due == KIND_A) ? wait_a : (due == KIND_B) ? wait_b : 16'd0;
      if (occupied >= capacity) begin
        ok = 1'b0;
      end else if (occupied == 0) begin
        if (run_kind == KIND_NONE || k == due) begin
          ok = 1'b1;
        end else if (due_waiters == 0) begin
          // The favored class has nobody waiting, so the streak is dropped.
          run_kind = KIND_NONE;
          run_len = '0;
          ok = 1'b1;
        end
      end else begin
        ok = (holder == k) && (k == due);
      end
      if (ok) begin
        if (occupied == 0) holder = k;
        occupied++;
        if (k == KIND_A) begin
          if (wait_a != 0) wait_a--;
        end else begin
          if (wait_b != 0) wait_b--;
        end
        if (run_kind == k) begin
          if (run_len != STREAK_LEN_MAX) run_len++;
        end else begin
          run_kind = k;
          run_len = 8'd1;
        end
      end
      return ok;
    endfunction

    // Works out the outcome of one accepted event.
    function void note_event(act_t act, logic cls);
      kind_t    k;
      outcome_t o;
      k = cls ? KIND_B : KIND_A;
      o = '0;
      case (act)
        ACT_ARRIVE: begin
          if (k == KIND_A) begin
            if (wait_a != WAIT_LIMIT) wait_a++;
          end else begin
            if (wait_b != WAIT_LIMIT) wait_b++;
          end
          o.granted = admit(k);
        end
        ACT_RETRY: begin
          o.granted = admit(k);
        end
        ACT_DEPART: begin
          if (occupied == 0) begin
            o.fault = 1'b1;
          end else begin
            occupied--;
            if (occupied == 0) holder = KIND_NONE;
          end
        end
        default: begin
        end
      endcase
      o.occupancy = occupied;
      o.holder = holder;
      o.streak = run_kind;
      o.count = run_len;
      expected_outcomes.push_back(o);
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compares one result item with the oldest outcome still owed.
    function void check_result(outcome_t got);
      outcome_t want;
      if (expected_outcomes.size() == 0) begin
        $display("%0t: result item with no event pending, actual %p", $time, got);
        errors++;
        return;
      end
      want = expected_outcomes.pop_front();
      check_field("granted", want.granted, got.granted);
      check_field("fault", want.fault, got.fault);
      check_field("occupancy", want.occupancy, got.occupancy);
      check_field("inside_kind", want.holder, got.holder);
      check_field("streak_kind", want.streak, got.streak);
      check_field("streak_count", want.count, got.count);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] action = ACT_IDLE;
  logic       user_class = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       granted;
  logic       fault;
  logic [7:0] occupancy;
  logic [1:0] inside_kind;
  logic [1:0] streak_kind;
  logic [7:0] streak_count;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_data = 8'd0;

  admission_tracker tracker = new();

  int send_idle_pct = 18;
  int recv_idle_pct = 61;
  logic long_hold_req = 1'b0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int cycle_count = 0;

  two_class_exclusive_admission_arbiter uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .user_class   (user_class),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .granted      (granted),
    .fault        (fault),
    .occupancy    (occupancy),
    .inside_kind  (inside_kind),
    .streak_kind  (streak_kind),
    .streak_count (streak_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Give up if the run takes far longer than any correct run could.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d outcomes still owed", $time,
               tracker.expected_outcomes.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: check each accepted item, then pick the next ready level.
  always @(posedge clk) begin
    outcome_t got;
    if (!rst && out_valid && out_ready) begin
      got.granted = granted;
      got.fault = fault;
      got.occupancy = occupancy;
      got.holder = kind_t'(inside_kind);
      got.streak = kind_t'(streak_kind);
      got.count = streak_count;
      tracker.check_result(got);
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (long_hold_req && !hold_done) begin
      // One long hold-off so that the block fills and stalls its input.
      hold_done = 1'b1;
      hold_left = 80;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one event after a random gap and waits until it is taken.
  task automatic send_item(act_t act, logic cls);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    user_class <= cls;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_event(act, cls);
  endtask

  // Stops offering and waits until every owed outcome has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.expected_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reconfigure(logic [7:0] cap, logic [7:0] lim, int s_pct, int r_pct);
    drain();
    write_reg(REG_SLOT_CAPACITY, cap);
    write_reg(REG_STREAK_MAX, lim);
    send_idle_pct = s_pct;
    recv_idle_pct <= r_pct;
  endtask

  // Random mix of events; a_pct is the share of class A requesters.
  task automatic run_mix(int count, int arrive_pct, int retry_pct, int depart_pct,
                         int a_pct);
    int   pick;
    act_t act;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < arrive_pct) begin
        act = ACT_ARRIVE;
      end else if (pick < arrive_pct + retry_pct) begin
        act = ACT_RETRY;
      end else if (pick < arrive_pct + retry_pct + depart_pct) begin
        act = ACT_DEPART;
      end else begin
        act = ACT_IDLE;
      end
      send_item(act, $urandom_range(99) >= a_pct);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, capacity 3 and streak limit 5.
    send_item(ACT_DEPART, 1'b0);   // leaving an empty resource
    send_item(ACT_IDLE, 1'b1);
    send_item(ACT_RETRY, 1'b1);    // retry with no prior arrive, admitted
    send_item(ACT_ARRIVE, 1'b0);   // blocked by class B inside
    send_item(ACT_ARRIVE, 1'b1);
    send_item(ACT_ARRIVE, 1'b1);   // resource now full
    send_item(ACT_ARRIVE, 1'b1);   // refused while full
    send_item(ACT_DEPART, 1'b1);
    send_item(ACT_DEPART, 1'b0);
    send_item(ACT_DEPART, 1'b0);   // empty again
    send_item(ACT_DEPART, 1'b1);   // leaving an empty resource once more
    send_item(ACT_RETRY, 1'b1);
    send_item(ACT_RETRY, 1'b1);    // streak reaches its limit
    send_item(ACT_ARRIVE, 1'b1);   // class B no longer favored
    send_item(ACT_DEPART, 1'b0);
    send_item(ACT_DEPART, 1'b0);
    send_item(ACT_ARRIVE, 1'b1);   // class A waits, so B stays out
    send_item(ACT_RETRY, 1'b0);    // class A takes over the streak
    send_item(ACT_DEPART, 1'b0);
    send_item(ACT_IDLE, 1'b0);

    // Directed: smallest capacity and streak limit.
    reconfigure(8'd1, 8'd1, 18, 61);
    send_item(ACT_ARRIVE, 1'b1);
    send_item(ACT_ARRIVE, 1'b1);   // full at one
    send_item(ACT_DEPART, 1'b1);
    send_item(ACT_RETRY, 1'b1);    // due class has no waiters, streak cleared
    send_item(ACT_DEPART, 1'b0);

    // Sender idles lightly, receiver heavily; one long receiver hold-off.
    reconfigure(8'd3, 8'd2, 18, 61);
    long_hold_req <= 1'b1;
    run_mix(170, 40, 25, 30, 50);
    reconfigure(8'd1, 8'd1, 18, 61);
    run_mix(150, 35, 30, 30, 50);

    // Sender idles heavily, receiver lightly. A long class A streak with
    // the largest settings, broken by a pause until all outcomes are back.
    reconfigure(8'd255, 8'd255, 61, 18);
    run_mix(190, 58, 10, 27, 92);
    drain();
    run_mix(190, 58, 10, 27, 92);
    // Capacity dropped below the current occupancy.
    reconfigure(8'd2, 8'd255, 61, 18);
    run_mix(60, 40, 25, 30, 70);
    while (tracker.occupied != 0) send_item(ACT_DEPART, 1'($urandom_range(1)));
    run_mix(60, 40, 25, 30, 70);

    // No idling on either side.
    reconfigure(8'd4, 8'd1, 0, 0);
    run_mix(150, 40, 25, 30, 40);
    reconfigure(8'd255, 8'd3, 0, 0);
    run_mix(100, 50, 20, 25, 50);

    drain();
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_outcomes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/tcea_pkg.sv
design/tcea_in_stage.sv
design/tcea_admit.sv
design/two_class_exclusive_admission_arbiter.sv
tb/testbench.sv
